/* src/depq_pkg.sv */
// Shared types and constants for the double-ended priority queue.
// No dependencies.
package depq_pkg;

    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 2;
    localparam int COUNT_OUT_W = 7;

    // operation codes on the kind field
    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_MAX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_MIN = 2'd2;

    typedef logic [KIND_W-1:0]         t_kind;
    typedef logic signed [VALUE_W-1:0] t_value;

    // per-cycle command broadcast along a chain of cells
    typedef struct packed {
        logic ins;    // place the key into sorted position
        logic shift;  // move every entry one cell toward the head
    } t_cell_ctl;

endpackage

/* src/depq_if.sv */
// Valid/ready channel interfaces for the queue's operation and result streams.
// Depends on depq_pkg.
interface depq_in_if import depq_pkg::*; ();
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_value value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

interface depq_out_if import depq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_value                 max_value;
    t_value                 min_value;
    logic                   is_empty;
    logic [COUNT_OUT_W-1:0] held_count;
    logic                   refused;

    modport source (output valid, max_value, min_value, is_empty, held_count, refused,
                    input ready);
    modport sink   (input valid, max_value, min_value, is_empty, held_count, refused,
                    output ready);
endinterface

/* src/double_ended_priority_queue_unit.sv */
// Top level of the double-ended priority queue: two sorted cell chains and
// the result register. Depends on depq_pkg, depq_if and depq_chain.
// Usage
//   i_in  : operation channel (kind, value). kind 0 inserts value, 1 removes
//           the largest entry, 2 removes the smallest; 3 does nothing.
//   o_out : one result per operation: largest and smallest held values
//           (both 0 when empty), is_empty, held_count (low 7 bits of the
//           count) and refused (insert dropped because the queue was full).
//   The result is registered on the input transfer and is valid in the cycle after it.
//   Throughput: one operation per cycle while o_out.ready is high. Every cell
//   of both chains updates in the same cycle from its own compare and its
//   neighbors' values, so the row of cells sets the rate, not the queue depth.
//   The min chain holds values ascending; the max chain holds the bitwise
//   complement of the values ascending, so its head is the complemented max.
//   Removing the min shifts the min chain and shortens the max chain;
//   removing the max does the reverse. Both ends are always at cell 0.
//   Reset: count cleared and result register emptied; cell contents are
//   left as they are and read only below the count.
//   Stall: a new operation is taken only if the waiting result transfers
//   in the same cycle; otherwise i_in.ready drops until the receiver takes it.
module double_ended_priority_queue_unit import depq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    depq_in_if.sink           i_in,
    depq_out_if.source        o_out
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;
    logic                   r_out_valid;
    t_value                 r_max;
    t_value                 r_min;
    logic                   r_empty;
    logic [COUNT_OUT_W-1:0] r_held;
    logic                   r_refused;

    logic      in_xfer;
    logic      refuse;
    t_cell_ctl ctl_min;
    t_cell_ctl ctl_max;
    t_value    min_head_next;
    t_value    max_head_next;

    // result slot frees up when empty or when it transfers this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_comb begin
        ctl_min = '0;
        ctl_max = '0;
        refuse  = 1'b0;
        n_count = r_count;
        if (in_xfer) begin
            case (i_in.kind)
                KIND_INSERT: begin
                    if (r_count == COUNT_W'(CAPACITY)) begin
                        refuse = 1'b1;
                    end else begin
                        ctl_min.ins = 1'b1;
                        ctl_max.ins = 1'b1;
                        n_count     = r_count + COUNT_W'(1);
                    end
                end
                KIND_DEL_MAX: begin
                    if (r_count != '0) begin
                        ctl_max.shift = 1'b1;
                        n_count       = r_count - COUNT_W'(1);
                    end
                end
                KIND_DEL_MIN: begin
                    if (r_count != '0) begin
                        ctl_min.shift = 1'b1;
                        n_count       = r_count - COUNT_W'(1);
                    end
                end
                default: begin
                    // no operation
                end
            endcase
        end
    end

    depq_chain #(.DEPTH(CAPACITY)) u_min_chain (
        .i_clk       (i_clk),
        .i_ctl       (ctl_min),
        .i_key       (i_in.value),
        .i_count     (r_count),
        .o_head_next (min_head_next)
    );

    // complemented values: ascending order here is descending in value
    depq_chain #(.DEPTH(CAPACITY)) u_max_chain (
        .i_clk       (i_clk),
        .i_ctl       (ctl_max),
        .i_key       (~i_in.value),
        .i_count     (r_count),
        .o_head_next (max_head_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with the state after this operation
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_empty   <= (n_count == '0);
            r_held    <= COUNT_OUT_W'(n_count);
            r_refused <= refuse;
            if (n_count == '0) begin
                r_max <= '0;
                r_min <= '0;
            end else begin
                r_max <= ~max_head_next;
                r_min <= min_head_next;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.max_value  = r_max;
    assign o_out.min_value  = r_min;
    assign o_out.is_empty   = r_empty;
    assign o_out.held_count = r_held;
    assign o_out.refused    = r_refused;

endmodule

/* src/depq_cell.sv */
// One cell of the sorted chain: holds one entry, inserts or shifts per command.
// Depends on depq_pkg.
module depq_cell import depq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_value    i_key,
    input  logic      i_occ,
    input  t_value    i_left_val,
    input  logic      i_left_gt,
    input  t_value    i_right_val,
    output t_value    o_val,
    output logic      o_gt,
    output t_value    o_next
);

    t_value r_val;
    t_value n_val;

    // empty cells count as +infinity
    assign o_gt = !i_occ || (r_val > i_key);

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (o_gt) begin
                n_val = i_left_gt ? i_left_val : i_key;
            end
        end else if (i_ctl.shift) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule

/* src/depq_chain.sv */
// Row of depq_cell instances holding a multiset in ascending order, head first.
// Depends on depq_pkg and depq_cell.
module depq_chain import depq_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  t_cell_ctl                    i_ctl,
    input  t_value                       i_key,
    input  logic [$clog2(DEPTH+1)-1:0]   i_count,
    output t_value                       o_head_next
);

    localparam int COUNT_W = $clog2(DEPTH + 1);

    t_value vals  [DEPTH];
    t_value nexts [DEPTH];
    logic   gts   [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_value left_val;
        logic   left_gt;
        t_value right_val;
        logic   occ;

        assign occ = COUNT_W'(i) < i_count;

        if (i == 0) begin : g_head
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_body
            assign left_val = vals[i-1];
            assign left_gt  = gts[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_val = vals[i];
        end else begin : g_inner
            assign right_val = vals[i+1];
        end

        depq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_key       (i_key),
            .i_occ       (occ),
            .i_left_val  (left_val),
            .i_left_gt   (left_gt),
            .i_right_val (right_val),
            .o_val       (vals[i]),
            .o_gt        (gts[i]),
            .o_next      (nexts[i])
        );
    end

    assign o_head_next = nexts[0];

endmodule

/* src/depq_checker.sv */
// Port-level checks for double_ended_priority_queue_unit, attached by bind.
// Depends on depq_pkg.
module depq_checker import depq_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input t_value                 out_max,
    input t_value                 out_min,
    input logic                   out_empty,
    input logic [COUNT_OUT_W-1:0] out_held
);

    // each operation transfer yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after operation transfer");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_empty |-> out_max == '0 && out_min == '0 && out_held == '0)
        else $error("empty queue reports nonzero values");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_empty |-> out_max >= out_min)
        else $error("largest value below smallest value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_max) && $stable(out_min))
        else $error("stalled result changed");

endmodule

bind double_ended_priority_queue_unit depq_checker u_depq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_max   (o_out.max_value),
    .out_min   (o_out.min_value),
    .out_empty (o_out.is_empty),
    .out_held  (o_out.held_count)
);
